@@ hw/rtl/bmqp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmqp_pkg: shared types and constants for the block matrix quadrant product
// sizes of the block stores, field widths, action and block codes, payloads
// ----------------------------------------------------------------------------
package bmqp_pkg;

	// largest block order the stores hold
	localparam int unsigned MAX_ORDER   = 64;
	localparam int unsigned IDX_W       = $clog2(MAX_ORDER);
	localparam int unsigned ADDR_W      = 2 * IDX_W;
	localparam int unsigned STORE_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int unsigned ELEM_W      = 8;
	localparam int unsigned PROD_W      = 2 * ELEM_W;
	localparam int unsigned SUM_W       = 23;
	localparam int unsigned ORDER_W     = 7;

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(8);
	localparam logic [ORDER_W-1:0] ORDER_MAX   = ORDER_W'(MAX_ORDER);

	// action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	// operand block codes
	localparam logic [1:0] BLK_A_LEFT   = 2'd0;
	localparam logic [1:0] BLK_A_RIGHT  = 2'd1;
	localparam logic [1:0] BLK_B_TOP    = 2'd2;
	localparam logic [1:0] BLK_B_BOTTOM = 2'd3;

	typedef struct packed {
		logic              action;
		logic [1:0]        operand_block;
		logic [IDX_W-1:0]  row_index;
		logic [IDX_W-1:0]  column_index;
		logic [ELEM_W-1:0] element_value;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] product_value;
		logic [IDX_W-1:0] result_row;
		logic [IDX_W-1:0] result_column;
	} result_t;

endpackage

@@ hw/rtl/block_matrix_quadrant_product_unit.sv @@
// ----------------------------------------------------------------------------
// block_matrix_quadrant_product_unit: one quadrant of a block matrix product
// C = A_left*B_top + A_right*B_bottom over four 64x64 byte stores
// ----------------------------------------------------------------------------
// A load transaction writes one byte into one of four block stores and is
// done in the cycle it is accepted; the next transaction may follow at once.
// A request transaction walks k from 0 to order-1, reading all four stores
// once per cycle through their single read port and doing two multiply-adds
// per k, so it holds the input side through the walk and the pipeline drain,
// plus the wait of the finished sum while the output register is still
// held, before the unit takes another transaction; the read/multiply/accumulate
// pipeline is three deep. The finished result sits in an output register,
// so the next transaction is accepted while that result still waits to be
// taken. order_in_use saturates at 64; a value of zero returns a zero sum.
// The stores have no reset: every entry a request reads must have been loaded
// first. The user writes configuration only while idle; the unit has no guard.
module block_matrix_quadrant_product_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// request / load channel
	input  logic                              req_valid,
	output logic                              req_stall,
	input  bmqp_pkg::item_t                   req_data,
	// result channel
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output bmqp_pkg::result_t                 rsp_data,
	// configuration: order_in_use
	input  logic                              cfg_we,
	input  logic [bmqp_pkg::ORDER_W-1:0]      cfg_data
);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                       state_q;
	logic [bmqp_pkg::ORDER_W-1:0]     order_q;
	logic [bmqp_pkg::ORDER_W-1:0]     eff_order;
	logic [bmqp_pkg::ORDER_W-1:0]     last_k_q;
	logic [bmqp_pkg::IDX_W-1:0]       k_q;
	logic [bmqp_pkg::IDX_W-1:0]       row_q;
	logic [bmqp_pkg::IDX_W-1:0]       col_q;
	logic [bmqp_pkg::SUM_W-1:0]       acc_q;

	logic                             accept;
	logic                             load_we;
	logic                             start_req;
	logic                             issue_last;
	logic                             out_free;

	logic [bmqp_pkg::ADDR_W-1:0]      wr_addr;
	logic [bmqp_pkg::ADDR_W-1:0]      a_addr;
	logic [bmqp_pkg::ADDR_W-1:0]      b_addr;

	// block stores, one write and one read port each
	logic [bmqp_pkg::ELEM_W-1:0]      a_left_mem   [bmqp_pkg::STORE_DEPTH];
	logic [bmqp_pkg::ELEM_W-1:0]      a_right_mem  [bmqp_pkg::STORE_DEPTH];
	logic [bmqp_pkg::ELEM_W-1:0]      b_top_mem    [bmqp_pkg::STORE_DEPTH];
	logic [bmqp_pkg::ELEM_W-1:0]      b_bottom_mem [bmqp_pkg::STORE_DEPTH];

	logic [bmqp_pkg::ELEM_W-1:0]      a_left_rd_q;
	logic [bmqp_pkg::ELEM_W-1:0]      a_right_rd_q;
	logic [bmqp_pkg::ELEM_W-1:0]      b_top_rd_q;
	logic [bmqp_pkg::ELEM_W-1:0]      b_bottom_rd_q;

	// pipeline: s1 = read data valid, s2 = products registered
	logic                             vld_s1;
	logic                             last_s1;
	logic                             vld_s2;
	logic                             last_s2;
	logic [bmqp_pkg::PROD_W-1:0]      prod_l_s2;
	logic [bmqp_pkg::PROD_W-1:0]      prod_r_s2;

	logic                             rsp_valid_q;
	bmqp_pkg::result_t                rsp_data_q;

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	// only the idle sequencer takes a transaction
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign load_we   = accept && (req_data.action == bmqp_pkg::ACT_LOAD);
	assign start_req = accept && (req_data.action == bmqp_pkg::ACT_REQUEST);

	// output register may take a new result when empty or being drained
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// order saturates at the store size
	assign eff_order = (order_q > bmqp_pkg::ORDER_MAX) ? bmqp_pkg::ORDER_MAX : order_q;

	// last k of the walk is issued this cycle
	assign issue_last = (state_q == ST_RUN) && ({1'b0, k_q} == last_k_q);

	// ------------------------------------------------------------------
	// addresses: row-major, row * MAX_ORDER + column
	// ------------------------------------------------------------------
	assign wr_addr = {req_data.row_index, req_data.column_index};
	assign a_addr  = {row_q, k_q};
	assign b_addr  = {k_q, col_q};

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= bmqp_pkg::ORDER_RESET;
		end else if (cfg_we) begin
			order_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// block stores: loads write in the accept cycle, requests read
	// only later, so a write and a read never meet on one entry
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (load_we && (req_data.operand_block == bmqp_pkg::BLK_A_LEFT)) begin
			a_left_mem[wr_addr] <= req_data.element_value;
		end
		a_left_rd_q <= a_left_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (load_we && (req_data.operand_block == bmqp_pkg::BLK_A_RIGHT)) begin
			a_right_mem[wr_addr] <= req_data.element_value;
		end
		a_right_rd_q <= a_right_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (load_we && (req_data.operand_block == bmqp_pkg::BLK_B_TOP)) begin
			b_top_mem[wr_addr] <= req_data.element_value;
		end
		b_top_rd_q <= b_top_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		if (load_we && (req_data.operand_block == bmqp_pkg::BLK_B_BOTTOM)) begin
			b_bottom_mem[wr_addr] <= req_data.element_value;
		end
		b_bottom_rd_q <= b_bottom_mem[b_addr];
	end

	// ------------------------------------------------------------------
	// pipeline control flags
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= (state_q == ST_RUN);
			last_s1 <= issue_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	// products of one k, registered before the accumulate
	always_ff @(posedge clk) begin
		prod_l_s2 <= a_left_rd_q * b_top_rd_q;
		prod_r_s2 <= a_right_rd_q * b_bottom_rd_q;
	end

	// ------------------------------------------------------------------
	// sequencer: walk k, drain the pipeline, hand the sum over
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_req) begin
						// empty sum when the order is zero
						state_q <= (eff_order == '0) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request context and running sum
	always_ff @(posedge clk) begin
		if (start_req) begin
			row_q    <= req_data.row_index;
			col_q    <= req_data.column_index;
			last_k_q <= eff_order - bmqp_pkg::ORDER_W'(1);
			k_q      <= '0;
			acc_q    <= '0;
		end else begin
			if (state_q == ST_RUN) begin
				k_q <= k_q + bmqp_pkg::IDX_W'(1);
			end
			if (vld_s2) begin
				acc_q <= acc_q + bmqp_pkg::SUM_W'(prod_l_s2)
				               + bmqp_pkg::SUM_W'(prod_r_s2);
			end
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			rsp_data_q.product_value <= acc_q;
			rsp_data_q.result_row    <= row_q;
			rsp_data_q.result_column <= col_q;
		end
	end

endmodule
